// ===== design/rdir_pkg.sv =====
// Shared widths, configuration types and pipeline records for the ray direction block.
package rdir_pkg;

  localparam int MAX_DIM_DEF  = 4096;
  localparam int DIR_FRAC_DEF = 14;

  localparam int COL_W   = 12;
  localparam int OFS_W   = 8;
  localparam int DIM_W   = 13;
  localparam int SCALE_W = 16;
  localparam int DIST_W  = 20;
  localparam int BASIS_W = 48;
  localparam int COMP_W  = 16;
  localparam int OUT_W   = 16;
  localparam int IDX_W   = 3;

  // Offsets from the image center in Q.8, view-plane point in Q.20.
  localparam int T_W     = 22;
  localparam int P_W     = 39;
  localparam int PD_W    = 32;
  // Direction components in Q.34 and their normalized magnitudes.
  localparam int C_W     = 56;
  localparam int MAG_W   = 30;
  localparam int SH_W    = 5;
  localparam int SUM_W   = 2 * MAG_W + 2;
  localparam int ROOT_W  = MAG_W + 1;
  localparam int Q_EXT_W = 33;

  typedef enum logic [IDX_W-1:0] {
    REG_BASIS_U    = 3'd0,
    REG_BASIS_V    = 3'd1,
    REG_BASIS_W    = 3'd2,
    REG_VIEW_DIST  = 3'd3,
    REG_SCALE_X    = 3'd4,
    REG_SCALE_Y    = 3'd5,
    REG_IMG_WIDTH  = 3'd6,
    REG_IMG_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [BASIS_W-1:0] basis_u;
    logic [BASIS_W-1:0] basis_v;
    logic [BASIS_W-1:0] basis_w;
    logic [DIST_W-1:0]  view_dist;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [2:0]            neg;
    logic [2:0][C_W-1:0]   mag;
  } vec_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  zero;
    logic [2:0][MAG_W-1:0] mag;
  } side_t;

endpackage

// ===== design/rdir_front.sv =====
// Front pipeline: view-plane point, basis products and signed direction magnitudes.
module rdir_front #(
  parameter int MAX_DIM = rdir_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rdir_pkg::COL_W-1:0]  col,
  input  logic [rdir_pkg::COL_W-1:0]  row,
  input  logic [rdir_pkg::OFS_W-1:0]  ox,
  input  logic [rdir_pkg::OFS_W-1:0]  oy,
  input  rdir_pkg::cfg_t              cfg,
  output rdir_pkg::vec_t              vec
);
  import rdir_pkg::*;

  logic [3:0]             v_r;
  logic [DIM_W-1:0]       w_c;
  logic [DIM_W-1:0]       h_c;
  logic signed [T_W-1:0]  tx_r;
  logic signed [T_W-1:0]  ty_r;
  logic signed [P_W-1:0]  px_r;
  logic signed [P_W-1:0]  py_r;
  logic [PD_W-1:0]        pd_r;
  logic signed [C_W-1:0]  prod_r [3][3];
  logic signed [C_W-1:0]  c_r [3];
  logic                   vld_r;
  logic [2:0]             vneg_r;
  logic [2:0][C_W-1:0]    vmag_r;

  // Dimensions above the supported maximum are treated as the maximum.
  assign w_c = (32'(cfg.width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.width;
  assign h_c = (32'(cfg.height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.height;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      vld_r <= 1'b0;
    end else if (en) begin
      v_r   <= {v_r[2:0], in_valid};
      vld_r <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= T_W'({col, 8'b0}) - T_W'({w_c, 7'b0}) + T_W'(ox);
      ty_r <= T_W'({row, 8'b0}) - T_W'({h_c, 7'b0}) + T_W'(oy);
      px_r <= $signed({1'b0, cfg.scale_x}) * tx_r;
      // Rows grow downward, so the vertical coordinate is flipped.
      py_r <= -($signed({1'b0, cfg.scale_y}) * ty_r);
      pd_r <= {cfg.view_dist, 12'b0};
      for (int i = 0; i < 3; i++) begin
        prod_r[i][0] <= $signed(cfg.basis_u[BASIS_W-1-COMP_W*i -: COMP_W]) * px_r;
        prod_r[i][1] <= $signed(cfg.basis_v[BASIS_W-1-COMP_W*i -: COMP_W]) * py_r;
        prod_r[i][2] <= $signed(cfg.basis_w[BASIS_W-1-COMP_W*i -: COMP_W])
                        * $signed({1'b0, pd_r});
        c_r[i]       <= prod_r[i][0] + prod_r[i][1] - prod_r[i][2];
        vneg_r[i]    <= c_r[i][C_W-1];
        vmag_r[i]    <= c_r[i][C_W-1] ? C_W'(-c_r[i]) : C_W'(c_r[i]);
      end
    end
  end

  assign vec.valid = vld_r;
  assign vec.neg   = vneg_r;
  assign vec.mag   = vmag_r;

endmodule

// ===== design/rdir_norm.sv =====
// Range reduction of the magnitudes and the sum of their squares.
module rdir_norm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  rdir_pkg::vec_t              vec,
  output logic                        out_valid,
  output rdir_pkg::side_t             side,
  output logic [rdir_pkg::SUM_W-1:0]  sum
);
  import rdir_pkg::*;

  logic [3:0]              v_r;
  logic                    out_valid_r;
  logic [C_W-1:0]          mx_r;
  logic [2:0]              neg1_r;
  logic [2:0][C_W-1:0]     mag1_r;
  logic [2:0]              neg2_r;
  logic [2:0][C_W-1:0]     mag2_r;
  logic                    zero2_r;
  logic [SH_W-1:0]         s_r;
  logic [SH_W-1:0]         s_nxt;
  side_t                   side3_r;
  logic [2*MAG_W-1:0]      sq_r [3];
  side_t                   side4_r;
  side_t                   side5_r;
  logic [SUM_W-1:0]        sum_r;
  logic [C_W-1:0]          m01;

  assign m01 = (vec.mag[0] > vec.mag[1]) ? vec.mag[0] : vec.mag[1];

  // Least right shift that brings the largest magnitude below 2^MAG_W.
  always_comb begin
    s_nxt = '0;
    for (int b = MAG_W; b < C_W; b++) begin
      if (mx_r[b]) begin
        s_nxt = SH_W'(b - MAG_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[2:0], vec.valid};
      out_valid_r <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r    <= (m01 > vec.mag[2]) ? m01 : vec.mag[2];
      neg1_r  <= vec.neg;
      mag1_r  <= vec.mag;
      neg2_r  <= neg1_r;
      mag2_r  <= mag1_r;
      zero2_r <= (mx_r == '0);
      s_r     <= s_nxt;
      side3_r.neg  <= neg2_r;
      side3_r.zero <= zero2_r;
      for (int i = 0; i < 3; i++) begin
        side3_r.mag[i] <= MAG_W'(mag2_r[i] >> s_r);
        sq_r[i]        <= side3_r.mag[i] * side3_r.mag[i];
      end
      side4_r <= side3_r;
      sum_r   <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      side5_r <= side4_r;
    end
  end

  assign out_valid = out_valid_r;
  assign side      = side5_r;
  assign sum       = sum_r;

endmodule

// ===== design/rdir_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module rdir_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  rdir_pkg::side_t              in_side,
  input  logic [rdir_pkg::SUM_W-1:0]   sum,
  output logic                         out_valid,
  output rdir_pkg::side_t              out_side,
  output logic [rdir_pkg::ROOT_W-1:0]  root
);
  import rdir_pkg::*;

  logic [SUM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];
  logic [ROOT_W-1:0] v_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int B = ROOT_W - 1 - i;
    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic              v_in;
    logic [SUM_W:0]    trial;
    logic              take;

    if (i == 0) begin : g_first
      assign rem_in  = sum;
      assign root_in = '0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
      assign v_in    = v_r[i-1];
    end

    // (root + 2^B)^2 - root^2, the cost of setting this bit.
    assign trial = ((SUM_W+1)'(root_in) << (B + 1)) + ((SUM_W+1)'(1) << (2 * B));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? rem_in - SUM_W'(trial) : rem_in;
        root_r[i] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];
  assign root      = root_r[ROOT_W-1];

endmodule

// ===== design/rdir_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rdir_div #(
  parameter int DIR_FRAC_BITS = rdir_pkg::DIR_FRAC_DEF,
  parameter int NUM_W         = rdir_pkg::MAG_W + DIR_FRAC_BITS + 1
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [NUM_W-1:0]             num,
  input  logic [rdir_pkg::ROOT_W-1:0]  den,
  output logic [DIR_FRAC_BITS:0]       quo
);
  import rdir_pkg::*;

  localparam int NSTG = DIR_FRAC_BITS + 1;

  logic [NUM_W-1:0]         rem_r [NSTG];
  logic [ROOT_W-1:0]        den_r [NSTG];
  logic [DIR_FRAC_BITS:0]   q_r   [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    localparam int K = DIR_FRAC_BITS - i;
    logic [NUM_W-1:0]       rem_in;
    logic [ROOT_W-1:0]      den_in;
    logic [DIR_FRAC_BITS:0] q_in;
    logic [NUM_W-1:0]       shifted;
    logic                   take;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign shifted = NUM_W'(den_in) << K;
    assign take    = rem_in >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= take ? rem_in - shifted : rem_in;
        den_r[i] <= den_in;
        q_r[i]   <= take ? (q_in | ((DIR_FRAC_BITS+1)'(1) << K)) : q_in;
      end
    end
  end

  assign quo = q_r[NSTG-1];

endmodule

// ===== design/pinhole_ray_direction.sv =====
// Top level of the pinhole camera primary ray direction pipeline.
//
// Each input request carries one pixel sample: column, row and a Q0.8
// sub-pixel offset. Each result carries the unit ray direction in signed
// Q1.14 (DIR_FRAC_BITS fraction bits) and a flag for a zero-length vector.
// Both channels use valid and stall; a request moves on an edge where valid
// is high and stall is low. The configuration channel writes one register
// per valid and ready edge; ready is always high. Write it only when idle.
// One request is taken every cycle while in_stall is low. Between a request
// and its result lie five front stages, five range reduction stages, one
// stage per root bit of the square root, a numerator stage, one per
// quotient bit of the three dividers and the output register.
// When the receiver stalls, one more result is caught in a skid register;
// then in_stall rises and the whole pipeline holds until the output drains.
// Synchronous reset empties the pipeline and loads the default camera.
module pinhole_ray_direction #(
  parameter int MAX_DIM       = rdir_pkg::MAX_DIM_DEF,
  parameter int DIR_FRAC_BITS = rdir_pkg::DIR_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rdir_pkg::COL_W-1:0]    in_pixel_col,
  input  logic [rdir_pkg::COL_W-1:0]    in_pixel_row,
  input  logic [rdir_pkg::OFS_W-1:0]    in_offset_x,
  input  logic [rdir_pkg::OFS_W-1:0]    in_offset_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rdir_pkg::OUT_W-1:0] out_dir_x,
  output logic signed [rdir_pkg::OUT_W-1:0] out_dir_y,
  output logic signed [rdir_pkg::OUT_W-1:0] out_dir_z,
  output logic                          out_zero_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rdir_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rdir_pkg::BASIS_W-1:0]  cfg_data
);
  import rdir_pkg::*;

  localparam int NUM_W = MAG_W + DIR_FRAC_BITS + 1;
  localparam int NSTG  = DIR_FRAC_BITS + 1;

  cfg_t                  cfg_r;
  logic                  en;
  vec_t                  vec;
  logic                  norm_valid;
  side_t                 norm_side;
  logic [SUM_W-1:0]      norm_sum;
  logic                  sq_valid;
  side_t                 sq_side;
  logic [ROOT_W-1:0]     sq_root;
  logic [ROOT_W-1:0]     len;
  logic                  nv_r;
  logic [2:0]            nneg_r;
  logic                  nzero_r;
  logic [NUM_W-1:0]      num_r [3];
  logic [ROOT_W-1:0]     den_r;
  logic [DIR_FRAC_BITS:0] quo [3];
  logic [NSTG-1:0]       dv_r;
  logic [2:0]            dneg_r [NSTG];
  logic                  dzero_r [NSTG];
  logic [OUT_W-1:0]      res [3];
  logic [Q_EXT_W-1:0]    qx [3];
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_dir_r [3];
  logic                  out_zero_r;
  logic                  skid_valid_r;
  logic [OUT_W-1:0]      skid_dir_r [3];
  logic                  skid_zero_r;
  logic                  pipe_v;
  logic                  out_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.basis_u   <= 48'h4000_0000_0000;
      cfg_r.basis_v   <= 48'h0000_4000_0000;
      cfg_r.basis_w   <= 48'h0000_0000_4000;
      cfg_r.view_dist <= 20'd25600;
      cfg_r.scale_x   <= 16'd4096;
      cfg_r.scale_y   <= 16'd4096;
      cfg_r.width     <= 13'd640;
      cfg_r.height    <= 13'd480;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASIS_U:    cfg_r.basis_u   <= cfg_data;
        REG_BASIS_V:    cfg_r.basis_v   <= cfg_data;
        REG_BASIS_W:    cfg_r.basis_w   <= cfg_data;
        REG_VIEW_DIST:  cfg_r.view_dist <= cfg_data[DIST_W-1:0];
        REG_SCALE_X:    cfg_r.scale_x   <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y:    cfg_r.scale_y   <= cfg_data[SCALE_W-1:0];
        REG_IMG_WIDTH:  cfg_r.width     <= cfg_data[DIM_W-1:0];
        REG_IMG_HEIGHT: cfg_r.height    <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline only halts once the skid register holds a result.
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  rdir_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .col      (in_pixel_col),
    .row      (in_pixel_row),
    .ox       (in_offset_x),
    .oy       (in_offset_y),
    .cfg      (cfg_r),
    .vec      (vec)
  );

  rdir_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vec       (vec),
    .out_valid (norm_valid),
    .side      (norm_side),
    .sum       (norm_sum)
  );

  rdir_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (norm_valid),
    .in_side   (norm_side),
    .sum       (norm_sum),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .root      (sq_root)
  );

  assign len = (sq_root == '0) ? ROOT_W'(1) : sq_root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (en) begin
      nv_r <= sq_valid;
    end
  end

  // Rounded quotient: add half the length before dividing.
  always_ff @(posedge clk) begin
    if (en) begin
      nneg_r  <= sq_side.neg;
      nzero_r <= sq_side.zero;
      den_r   <= len;
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUM_W'(sq_side.mag[i]) << DIR_FRAC_BITS) + NUM_W'(len >> 1);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    rdir_div #(.DIR_FRAC_BITS(DIR_FRAC_BITS), .NUM_W(NUM_W)) u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[i]),
      .den (den_r),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[NSTG-2:0], nv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dneg_r[0]  <= nneg_r;
      dzero_r[0] <= nzero_r;
      for (int k = 1; k < NSTG; k++) begin
        dneg_r[k]  <= dneg_r[k-1];
        dzero_r[k] <= dzero_r[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i]  = dneg_r[NSTG-1][i] ? Q_EXT_W'(-Q_EXT_W'(quo[i])) : Q_EXT_W'(quo[i]);
      res[i] = dzero_r[NSTG-1] ? '0 : qx[i][OUT_W-1:0];
    end
  end

  assign pipe_v  = dv_r[NSTG-1];
  assign out_adv = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r  <= skid_valid_r || pipe_v;
      skid_valid_r <= 1'b0;
    end else if (en && pipe_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      for (int i = 0; i < 3; i++) begin
        out_dir_r[i] <= skid_valid_r ? skid_dir_r[i] : res[i];
      end
      out_zero_r <= skid_valid_r ? skid_zero_r : dzero_r[NSTG-1];
    end else if (en && pipe_v) begin
      for (int i = 0; i < 3; i++) begin
        skid_dir_r[i] <= res[i];
      end
      skid_zero_r <= dzero_r[NSTG-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dir_x       = out_dir_r[0];
  assign out_dir_y       = out_dir_r[1];
  assign out_dir_z       = out_dir_r[2];
  assign out_zero_length = out_zero_r;

endmodule

// ===== design/rdir_chk.sv =====
// Port-level checks on the ray direction block, bound to its top level.
module rdir_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rdir_pkg::OUT_W-1:0]    out_dir_x,
  input logic [rdir_pkg::OUT_W-1:0]    out_dir_y,
  input logic [rdir_pkg::OUT_W-1:0]    out_dir_z,
  input logic                          out_zero_length
);

  // A held result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A zero-length flag always comes with an all-zero direction.
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_dir_x == '0 && out_dir_y == '0 && out_dir_z == '0)
    else $error("zero-length result with nonzero direction");

  // Input backpressure only happens while a result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // The cycle after reset the output is empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind pinhole_ray_direction rdir_chk u_rdir_chk (.*);
